// ===== rtl/core/lsbp_pkg.sv =====
// shared constants and types of the lsb-first bit packer
`timescale 1ns / 1ps
package lsbp_pkg;

  localparam int MAX_FIELD_BITS = 64;
  localparam int FIELD_W        = 64;
  localparam int COUNT_W        = 7;
  localparam int BYTE_W         = 8;
  localparam int PEND_W         = 7;
  localparam int HAVE_W         = 3;
  localparam int NBYTES_W       = 4;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // one queued request: up to eight finished bytes, earliest in the low byte
  typedef struct packed {
    logic [FIELD_W-1:0]  bytes;
    logic [NBYTES_W-1:0] nbytes;
  } lsbp_entry_t;

endpackage

// ===== rtl/core/lsbp_front.sv =====
// front end: holds the partial byte and turns each request into whole bytes
`timescale 1ns / 1ps
module lsbp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept_i,
  input  logic                         op_i,
  input  logic [lsbp_pkg::FIELD_W-1:0] field_data_i,
  input  logic [lsbp_pkg::COUNT_W-1:0] bit_count_i,
  output logic                         push_o,
  output lsbp_pkg::lsbp_entry_t        entry_o
);
  import lsbp_pkg::*;

  localparam int COMB_W = FIELD_W + BYTE_W;

  logic [PEND_W-1:0]   pend_bits_r, pend_bits_nxt;
  logic [HAVE_W-1:0]   pend_cnt_r, pend_cnt_nxt;
  logic [COUNT_W-1:0]  cnt_sat;
  logic [FIELD_W-1:0]  data_mask;
  logic [FIELD_W-1:0]  data_masked;
  logic [COMB_W-1:0]   comb;
  logic [COMB_W-1:0]   comb_rest;
  logic [COUNT_W:0]    total;
  logic [NBYTES_W-1:0] n_app;

  always_comb begin
    if (bit_count_i > COUNT_W'(MAX_FIELD_BITS)) begin
      cnt_sat = COUNT_W'(MAX_FIELD_BITS);
    end else begin
      cnt_sat = bit_count_i;
    end
    if (cnt_sat >= COUNT_W'(FIELD_W)) begin
      data_mask = '1;
    end else begin
      data_mask = (FIELD_W'(1) << cnt_sat) - FIELD_W'(1);
    end
    data_masked = field_data_i & data_mask;
    comb  = {{(COMB_W-PEND_W){1'b0}}, pend_bits_r}
          | ({{BYTE_W{1'b0}}, data_masked} << pend_cnt_r);
    total = {{(COUNT_W+1-HAVE_W){1'b0}}, pend_cnt_r} + {1'b0, cnt_sat};
    n_app = total[NBYTES_W+2:3];
    comb_rest = comb >> {n_app, 3'b000};
  end

  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    push_o        = 1'b0;
    entry_o.bytes = comb[FIELD_W-1:0];
    entry_o.nbytes = n_app;
    if (op_i == OP_FLUSH) begin
      entry_o.bytes  = {{(FIELD_W-PEND_W){1'b0}}, pend_bits_r};
      entry_o.nbytes = (pend_cnt_r != '0) ? NBYTES_W'(1) : '0;
    end
    if (accept_i) begin
      push_o = (entry_o.nbytes != '0);
      if (op_i == OP_FLUSH) begin
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
      end else begin
        pend_bits_nxt = comb_rest[PEND_W-1:0];
        pend_cnt_nxt  = total[HAVE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/lsbp_queue.sv =====
// short queue of byte groups between front and back
`timescale 1ns / 1ps
module lsbp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  lsbp_pkg::lsbp_entry_t entry_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output lsbp_pkg::lsbp_entry_t entry_o
);
  import lsbp_pkg::*;

  lsbp_entry_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full_o  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_r != '0);
  assign entry_o = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= entry_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/lsbp_back.sv =====
// back end: unloads one byte group a byte per cycle into the output register, while the receiver keeps popping
`timescale 1ns / 1ps
module lsbp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid_i,
  input  lsbp_pkg::lsbp_entry_t       q_entry_i,
  output logic                        q_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [lsbp_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        out_last_o
);
  import lsbp_pkg::*;

  logic [FIELD_W-1:0]  cur_data_r, cur_data_nxt;
  logic [NBYTES_W-1:0] cur_left_r, cur_left_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic                emit, cur_done;

  assign empty_o    = !out_valid_r;
  assign out_byte_o = out_byte_r;
  assign out_last_o = out_last_r;

  always_comb begin
    emit     = (cur_left_r != '0) && (!out_valid_r || pop_i);
    cur_done = (cur_left_r == '0) || (emit && cur_left_r == NBYTES_W'(1));
    q_pop_o  = cur_done && q_valid_i;

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_data_r[BYTE_W-1:0];
      out_last_nxt  = (cur_left_r == NBYTES_W'(1));
    end else if (pop_i) begin
      out_valid_nxt = 1'b0;
    end

    cur_data_nxt = cur_data_r;
    cur_left_nxt = cur_left_r;
    if (q_pop_o) begin
      cur_data_nxt = q_entry_i.bytes;
      cur_left_nxt = q_entry_i.nbytes;
    end else if (emit) begin
      cur_data_nxt = cur_data_r >> BYTE_W;
      cur_left_nxt = cur_left_r - NBYTES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    cur_data_r <= cur_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_left_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_left_r  <= cur_left_nxt;
    end
  end

endmodule

// ===== rtl/core/lsb_first_bit_packer_core.sv =====
// top level of the lsb-first bit packer: front, queue and back wired together
//
//  channel   direction  handshake        payload
//  request   in         push / full      in_op, in_field_data, in_bit_count
//  byte      out        empty / pop      out_byte, out_last_of_item
//
// - a request is taken when push is high while full is low; up to eight bytes follow
// - bytes leave one per cycle while pop is held high, so a 64-bit append puts eight bytes on the output
// - the byte output port is the limit; the front keeps taking requests until the
//   four-entry byte-group queue fills
// - a held pop stall fills the output register, then the queue, then raises full
// - synchronous active-low reset empties the partial byte, the queue and the output
`timescale 1ns / 1ps
module lsb_first_bit_packer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_op,
  input  logic [lsbp_pkg::FIELD_W-1:0] in_field_data,
  input  logic [lsbp_pkg::COUNT_W-1:0] in_bit_count,
  output logic                         empty,
  input  logic                         pop,
  output logic [lsbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_last_of_item
);
  import lsbp_pkg::*;

  logic        accept;
  logic        f_push;
  lsbp_entry_t f_entry;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  lsbp_entry_t q_entry;

  // request taken when the queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  // front: merge the new bits with the partial byte, split off whole bytes
  lsbp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept_i     (accept),
    .op_i         (in_op),
    .field_data_i (in_field_data),
    .bit_count_i  (in_bit_count),
    .push_o       (f_push),
    .entry_o      (f_entry)
  );

  // decoupling queue, one entry per request that yields bytes
  lsbp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .entry_i (f_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // back: serialize the bytes, last byte of the request marked
  lsbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte),
    .out_last_o (out_last_of_item)
  );

endmodule

// ===== bench/lsbp_stream_checker.sv =====
// byte stream predictor and comparator for the lsb-first bit packer bench
`timescale 1ns / 1ps
module lsbp_stream_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         full,
  input  logic                         in_op,
  input  logic [lsbp_pkg::FIELD_W-1:0] in_field_data,
  input  logic [lsbp_pkg::COUNT_W-1:0] in_bit_count,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [lsbp_pkg::BYTE_W-1:0]  out_byte,
  input  logic                         out_last_of_item,
  output int                           fail_count,
  output int                           bytes_waiting,
  output int                           requests_taken,
  output int                           flushes_taken,
  output int                           bytes_checked
);
  import lsbp_pkg::*;

  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } stream_byte_t;

  stream_byte_t      byte_exp_q[$];
  logic [PEND_W-1:0] partial_bits;
  int unsigned       partial_cnt;

  initial begin
    fail_count     = 0;
    bytes_waiting  = 0;
    requests_taken = 0;
    flushes_taken  = 0;
    bytes_checked  = 0;
    partial_bits   = '0;
    partial_cnt    = 0;
  end

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    if (fail_count < MAX_PRINTED)
      $display("%0t ns: mismatch on %s, got %02h expected %02h", $time, what, got, want);
    fail_count++;
  endtask

  // appends the bytes one request completes to the expected stream
  task automatic pack_request(input logic op, input logic [FIELD_W-1:0] data,
                              input logic [COUNT_W-1:0] count);
    logic [FIELD_W-1:0] bits;
    logic [BYTE_W-1:0]  next_byte;
    int unsigned        left;
    int unsigned        need;
    int unsigned        n_bytes;
    int unsigned        idx;
    stream_byte_t       entry;
    if (op == OP_FLUSH) begin
      if (partial_cnt != 0) begin
        entry.value = {1'b0, partial_bits};
        entry.last  = 1'b1;
        byte_exp_q.push_back(entry);
      end
      partial_bits = '0;
      partial_cnt  = 0;
    end else begin
      left    = (count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : count;
      bits    = (left >= FIELD_W) ? data : data & ((64'd1 << left) - 64'd1);
      n_bytes = (partial_cnt + left) / 8;
      idx     = 0;
      while (partial_cnt + left >= 8) begin
        need         = 8 - partial_cnt;
        next_byte    = {1'b0, partial_bits} | (bits[7:0] << partial_cnt);
        bits         = bits >> need;
        left         = left - need;
        partial_bits = '0;
        partial_cnt  = 0;
        entry.value  = next_byte;
        entry.last   = (idx == n_bytes - 1);
        byte_exp_q.push_back(entry);
        idx++;
      end
      partial_bits = partial_bits | (bits[6:0] << partial_cnt);
      partial_cnt  = partial_cnt + left;
    end
  endtask

  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst_n) begin
      byte_exp_q.delete();
      partial_bits = '0;
      partial_cnt  = 0;
    end else begin
      if (push && !full) begin
        pack_request(in_op, in_field_data, in_bit_count);
        requests_taken++;
        if (in_op == OP_FLUSH)
          flushes_taken++;
      end
      if (pop && !empty) begin
        if (byte_exp_q.size() == 0) begin
          report_mismatch("unexpected byte", out_byte, '0);
        end else begin
          want = byte_exp_q.pop_front();
          if (out_byte !== want.value)
            report_mismatch("out_byte", out_byte, want.value);
          if (out_last_of_item !== want.last)
            report_mismatch("out_last_of_item", {7'd0, out_last_of_item}, {7'd0, want.last});
          bytes_checked++;
        end
      end
    end
    bytes_waiting = byte_exp_q.size();
  end

endmodule

// ===== bench/tb_lsb_first_bit_packer_core.sv =====
// top of the lsb-first bit packer bench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module tb_lsb_first_bit_packer_core;
  import lsbp_pkg::*;

  localparam int CLK_HALF_NS      = 4;
  localparam int RESET_CYCLES     = 4;
  // generous bound on the whole run, even at the slow profile
  localparam int CYCLE_LIMIT      = 200000;
  // cycles to watch for stray bytes once the expected stream is empty
  localparam int TAIL_CYCLES      = 24;
  localparam int RANDOM_PER_PHASE = 104;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                push             = 1'b0;
  logic                in_op            = OP_APPEND;
  logic [FIELD_W-1:0]  in_field_data    = '0;
  logic [COUNT_W-1:0]  in_bit_count     = '0;
  logic                pop              = 1'b0;
  logic                full;
  logic                empty;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last_of_item;

  int fail_count;
  int bytes_waiting;
  int requests_taken;
  int flushes_taken;
  int bytes_checked;

  // chance in a hundred that each side sits out a cycle
  int send_idle_pct = 8;
  int recv_idle_pct = 81;
  int cycle_count   = 0;

  always #CLK_HALF_NS clk = ~clk;

  lsb_first_bit_packer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_field_data    (in_field_data),
    .in_bit_count     (in_bit_count),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item)
  );

  // watches both channels, predicts the byte stream and counts mismatches
  lsbp_stream_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_field_data    (in_field_data),
    .in_bit_count     (in_bit_count),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .fail_count       (fail_count),
    .bytes_waiting    (bytes_waiting),
    .requests_taken   (requests_taken),
    .flushes_taken    (flushes_taken),
    .bytes_checked    (bytes_checked)
  );

  // receiver: decides pop on every falling edge, stalling at the current rate
  always @(negedge clk) begin
    pop = (rst_n === 1'b1) && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on the total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_count, bytes_waiting);
      $display("lsb_first_bit_packer_core test failed");
      $finish;
    end
  end

  // one request: optional idle cycles, then hold it until the block takes it;
  // entered and left on a falling edge so push stays high between back-to-back requests
  task automatic send_request(input logic op, input logic [FIELD_W-1:0] data,
                              input logic [COUNT_W-1:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push          = 1'b1;
    in_op         = op;
    in_field_data = data;
    in_bit_count  = count;
    @(posedge clk);
    while (full)
      @(posedge clk);
    @(negedge clk);
  endtask

  // sender holds off until every predicted byte has left the block
  task automatic wait_for_drain();
    push = 1'b0;
    while (bytes_waiting != 0)
      @(negedge clk);
  endtask

  // random mix: mostly appends of any size, some tiny ones, some counts past the
  // maximum, and a steady share of flushes so partial bytes get padded often
  task automatic send_random_requests(input int total);
    int                 pick;
    logic               op;
    logic [FIELD_W-1:0] data;
    logic [COUNT_W-1:0] count;
    repeat (total) begin
      pick = $urandom_range(99);
      data = {$urandom, $urandom};
      op   = OP_APPEND;
      if (pick < 15) begin
        op    = OP_FLUSH;
        count = COUNT_W'($urandom_range(127));
      end else if (pick < 30) begin
        count = COUNT_W'($urandom_range(8));
      end else if (pick < 40) begin
        count = COUNT_W'($urandom_range(127, 65));
      end else begin
        count = COUNT_W'($urandom_range(64));
      end
      send_request(op, data, count);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed requests, under the slow receiver profile
    // zero count with all data bits set: nothing comes out, nothing changes
    send_request(OP_APPEND, {FIELD_W{1'b1}}, 7'd0);
    // flush with nothing pending, other fields at their maximum
    send_request(OP_FLUSH, {FIELD_W{1'b1}}, 7'd127);
    // full-width fields, all ones then all zeros: eight bytes each
    send_request(OP_APPEND, {FIELD_W{1'b1}}, 7'd64);
    send_request(OP_APPEND, {FIELD_W{1'b0}}, 7'd64);
    // counts above the maximum saturate to a full-width field
    send_request(OP_APPEND, 64'hA5A5_5A5A_C3C3_3C3C, 7'd127);
    send_request(OP_APPEND, 64'h0123_4567_89AB_CDEF, 7'd65);
    // data bits above the count must be dropped
    send_request(OP_APPEND, {FIELD_W{1'b1}}, 7'd3);
    // zero count while bits are pending
    send_request(OP_APPEND, {FIELD_W{1'b1}}, 7'd0);
    // completes the byte that was started: three ones then five zeros
    send_request(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFE0, 7'd5);
    // single pending bit padded out by a flush, then a flush with nothing left
    send_request(OP_APPEND, 64'h1, 7'd1);
    send_request(OP_FLUSH, 64'h0, 7'd0);
    send_request(OP_FLUSH, 64'hDEAD_BEEF_0BAD_F00D, 7'd64);
    // seven pending bits followed by a full field: eight bytes, seven bits left
    send_request(OP_APPEND, 64'h55, 7'd7);
    send_request(OP_APPEND, 64'hFEDC_BA98_7654_3210, 7'd64);
    send_request(OP_FLUSH, {FIELD_W{1'b1}}, 7'd64);
    // byte-aligned and just past a byte
    send_request(OP_APPEND, 64'h3C, 7'd8);
    send_request(OP_APPEND, 64'h1FF, 7'd9);
    send_request(OP_APPEND, {FIELD_W{1'b1}}, 7'd63);
    send_request(OP_FLUSH, 64'h0, 7'd0);
    // a pending zero bit flushes as an all-zero byte
    send_request(OP_APPEND, 64'h0, 7'd1);
    send_request(OP_FLUSH, 64'h0, 7'd0);

    // sender pauses until the stream is fully drained
    wait_for_drain();
    send_random_requests(RANDOM_PER_PHASE);
    wait_for_drain();

    // swap the profiles: sender mostly idle, receiver nearly always ready
    send_idle_pct = 81;
    recv_idle_pct = 8;
    send_random_requests(RANDOM_PER_PHASE);
    wait_for_drain();

    // both sides at full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_requests(RANDOM_PER_PHASE);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d requests (%0d flushes) and checked %0d stream bytes",
             requests_taken, flushes_taken, bytes_checked);
    $display("profiles: slow receiver, slow sender, no idling; %0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("lsb_first_bit_packer_core test passed");
    end else begin
      $display("lsb_first_bit_packer_core test failed");
    end
    $finish;
  end

endmodule
